@@ src/mwpo_pkg.sv @@
// shared constants, types and codes for the multi-waveform phase oscillator
`timescale 1ns / 1ps
`default_nettype none

package mwpo_pkg;

  localparam int PHASE_BITS = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int MAX_FRAMES_DEF = 64;

  localparam int FRAME_BITS = 7;
  localparam int WAVE_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_INDEX_BITS = 1;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_INCREMENT = 1'd1;

  // waveform codes
  localparam logic [WAVE_BITS-1:0] WAVE_SINE = 3'd0;
  localparam logic [WAVE_BITS-1:0] WAVE_SAW = 3'd1;
  localparam logic [WAVE_BITS-1:0] WAVE_SQUARE = 3'd2;
  localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 3'd3;
  localparam logic [WAVE_BITS-1:0] WAVE_ROUNDED = 3'd4;

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam int ONE_CODE = 1 << (SAMPLE_BITS - 1);
  localparam sample_t MAX_CODE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t MIN_CODE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam phase_t HALF_TURN = phase_t'(1) << (PHASE_BITS - 1);

  // band edges of the rounded square, scaled by ten
  localparam int BAND_BITS = PHASE_BITS + 4;
  localparam logic [BAND_BITS-1:0] BAND_X1 = BAND_BITS'(1) << (PHASE_BITS - 1);
  localparam logic [BAND_BITS-1:0] BAND_X9 = BAND_BITS'(9) << (PHASE_BITS - 1);
  localparam logic [BAND_BITS-1:0] BAND_X11 = BAND_BITS'(11) << (PHASE_BITS - 1);
  localparam logic [BAND_BITS-1:0] BAND_X19 = BAND_BITS'(19) << (PHASE_BITS - 1);

  // 5 pi in Q32, split for the shared multiplier
  localparam int FIVE_PI_BITS = 37;
  localparam logic [FIVE_PI_BITS-1:0] FIVE_PI_Q32 = 37'd67465188523;
  localparam int FIVE_PI_LO_BITS = 18;
  localparam int FIVE_PI_HI_BITS = FIVE_PI_BITS - FIVE_PI_LO_BITS;

  // quarter-wave table build
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

endpackage

`default_nettype wire

@@ src/mwpo_if.sv @@
// request and sample channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface mwpo_req_if import mwpo_pkg::*; ();
  logic valid;
  logic ready;
  logic [FRAME_BITS-1:0] frame_count;
  modport source (output valid, output frame_count, input ready);
  modport sink (input valid, input frame_count, output ready);
endinterface

interface mwpo_rsp_if import mwpo_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic last;
  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

@@ src/mwpo_qrom.sv @@
// quarter-wave sine table with registered read
`timescale 1ns / 1ps
`default_nettype none

module mwpo_qrom import mwpo_pkg::*; #(
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic [TABLE_ADDR_BITS:0]   addr,
  output logic      [SAMPLE_BITS-2:0]     data
);

  localparam int AW = TABLE_ADDR_BITS + 1;
  localparam int DEPTH = (1 << TABLE_ADDR_BITS) + 1;
  localparam int VW = SAMPLE_BITS - 1;

  typedef logic [DEPTH-1:0][VW-1:0] rom_t;

  // sin(pi/2 * a / 2^TABLE_ADDR_BITS) by an eleven-term series in Q30
  function automatic logic [VW-1:0] quarter_entry(input logic [AW-1:0] a);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x = (HALF_PI_Q30 * 64'(a)) >> TABLE_ADDR_BITS;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[k-1]);
      if (k[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'(ONE_CODE) + (64'd1 << 29)) >> 30;
    if (v > 64'(MAX_CODE)) begin
      v = 64'(MAX_CODE);
    end
    return v[VW-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int a = 0; a < DEPTH; a++) begin
      t[a] = quarter_entry(AW'(a));
    end
    return t;
  endfunction

  localparam rom_t QUARTER = build_rom();

  always_ff @(posedge clk) begin
    data <= QUARTER[addr];
  end

endmodule

`default_nettype wire

@@ src/mwpo_mul.sv @@
// phase times 5 pi, two passes through one 32x19 multiplier
`timescale 1ns / 1ps
`default_nettype none

module mwpo_mul import mwpo_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire phase_t operand,
  output logic        done,
  output phase_t      result
);

  localparam int PROD_BITS = PHASE_BITS + FIVE_PI_HI_BITS;
  localparam int ACC_BITS = PHASE_BITS + 32;

  localparam logic [1:0] MUL_IDLE = 2'd0;
  localparam logic [1:0] MUL_HI = 2'd1;
  localparam logic [1:0] MUL_ACC = 2'd2;

  localparam logic [FIVE_PI_HI_BITS-1:0] F_LO =
    FIVE_PI_HI_BITS'(FIVE_PI_Q32[FIVE_PI_LO_BITS-1:0]);
  localparam logic [FIVE_PI_HI_BITS-1:0] F_HI = FIVE_PI_Q32[FIVE_PI_BITS-1:FIVE_PI_LO_BITS];

  logic [1:0]                 step;
  phase_t                     opnd;
  logic [PROD_BITS-1:0]       prod;
  logic [ACC_BITS-1:0]        acc;
  phase_t                     mul_a;
  logic [FIVE_PI_HI_BITS-1:0] mul_b;
  logic [PROD_BITS-1:0]       mul_p;

  // low half of the constant first, high half on the next pass
  assign mul_a = start ? operand : opnd;
  assign mul_b = start ? F_LO : F_HI;
  assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

  assign result = acc[ACC_BITS-1:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= MUL_IDLE;
      done <= 1'b0;
    end else if (start) begin
      step <= MUL_HI;
      done <= 1'b0;
    end else begin
      case (step)
        MUL_HI: step <= MUL_ACC;
        MUL_ACC: begin
          step <= MUL_IDLE;
          done <= 1'b1;
        end
        default: step <= MUL_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd <= operand;
      prod <= mul_p;
    end else if (step == MUL_HI) begin
      acc <= ACC_BITS'(prod);
      prod <= mul_p;
    end else if (step == MUL_ACC) begin
      acc <= acc + ACC_BITS'({prod, {FIVE_PI_LO_BITS{1'b0}}});
    end
  end

endmodule

`default_nettype wire

@@ src/multi_waveform_phase_oscillator.sv @@
// multi-waveform phase-accumulator oscillator, top level
//
//   channel   dir  role    payload
//   req       in   sink    frame_count[6:0]
//   rsp       out  source  sample[15:0] signed, last
//   cfg_*     in   write   cfg_index[0], cfg_data[31:0]
//
// saw, square, triangle and the flat bands of rounded square pass calc then emit; sine
// also passes the sine state (registered quarter-table read), and the curved part of
// rounded square the multiply and sine states (two passes through the shared multiplier,
// then the table read). a request of n samples keeps req.ready low after its accept until
// its last sample is loaded. reset clears phase, registers and control; the table is a
// constant rom. a sample not yet taken holds the next finished one; the sequencer waits for the slot.
`timescale 1ns / 1ps
`default_nettype none

module multi_waveform_phase_oscillator import mwpo_pkg::*; #(
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  mwpo_req_if.sink                       req,
  mwpo_rsp_if.source                     rsp,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int SW = SAMPLE_BITS + 2;
  localparam int TAB = TABLE_ADDR_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_MUL = 3'd2;
  localparam logic [2:0] ST_SINE = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam logic [TAB:0] TAB_N = (TAB + 1)'(1) << TAB;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_next;
  phase_t               phase;
  phase_t               phase_next;
  logic [WAVE_BITS-1:0] waveform;
  phase_t               phase_inc;
  sample_t              res;
  sample_t              res_next;
  logic                 neg;
  logic                 out_valid;
  sample_t              out_sample;
  logic                 out_last;
  logic                 out_load;
  logic                 mul_start;
  logic                 mul_done;
  phase_t               mul_result;

  logic [FRAME_BITS-1:0]  n_sat;
  phase_t                 angle;
  logic [1:0]             quad;
  logic [TAB-1:0]         idx;
  logic [TAB:0]           rom_addr;
  logic [SAMPLE_BITS-2:0] rom_data;
  sample_t                rom_ext;

  logic [SAMPLE_BITS-1:0] two_t;
  logic signed [SW-1:0]   two_t_s;
  logic signed [SW-1:0]   one_s;
  logic signed [SW-1:0]   max_s;
  logic signed [SW-1:0]   saw_s;
  logic signed [SW-1:0]   dev_s;
  logic signed [SW-1:0]   dev_abs;
  logic signed [SW-1:0]   tri_s;
  logic [BAND_BITS-1:0]   p10;
  logic                   band_hi;
  logic                   band_lo;
  sample_t                direct;

  mwpo_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .operand (phase),
    .done    (mul_done),
    .result  (mul_result)
  );

  mwpo_qrom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_qrom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.sample = out_sample;
  assign rsp.last = out_last;

  assign n_sat = (req.frame_count > FRAME_BITS'(MAX_FRAMES)) ?
                 FRAME_BITS'(MAX_FRAMES) : req.frame_count;

  // table address: the phase for sine, minus the 5 pi product for rounded square
  assign angle = (state == ST_MUL) ? (phase_t'(0) - mul_result) : phase;
  assign quad = angle[PHASE_BITS-1 -: 2];
  assign idx = angle[PHASE_BITS-3 -: TAB];
  assign rom_addr = quad[0] ? (TAB_N - {1'b0, idx}) : {1'b0, idx};
  assign rom_ext = {1'b0, rom_data};

  // waveforms that need no table
  assign two_t = phase[PHASE_BITS-1 -: SAMPLE_BITS];
  assign two_t_s = {2'b00, two_t};
  assign one_s = SW'(ONE_CODE);
  assign max_s = SW'(MAX_CODE);
  assign saw_s = one_s - two_t_s;
  assign dev_s = two_t_s - one_s;
  assign dev_abs = (dev_s < 0) ? -dev_s : dev_s;
  assign tri_s = (dev_abs <<< 1) - one_s;
  assign p10 = ({4'b0000, phase} << 3) + ({4'b0000, phase} << 1);
  assign band_hi = (p10 >= BAND_X11) && (p10 <= BAND_X19);
  assign band_lo = (p10 >= BAND_X1) && (p10 <= BAND_X9);

  always_comb begin
    case (waveform)
      WAVE_SAW: direct = (saw_s > max_s) ? MAX_CODE : saw_s[SAMPLE_BITS-1:0];
      WAVE_SQUARE: direct = (phase <= HALF_TURN) ? MAX_CODE : MIN_CODE;
      WAVE_TRIANGLE: direct = (tri_s > max_s) ? MAX_CODE : tri_s[SAMPLE_BITS-1:0];
      default: direct = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    phase_next = phase;
    res_next = res;
    mul_start = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req.valid && (n_sat != '0)) begin
          cnt_next = n_sat[CNT_W-1:0];
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        case (waveform)
          WAVE_SINE: state_next = ST_SINE;
          WAVE_ROUNDED: begin
            if (band_hi) begin
              res_next = MAX_CODE;
              state_next = ST_EMIT;
            end else if (band_lo) begin
              res_next = MIN_CODE;
              state_next = ST_EMIT;
            end else begin
              mul_start = 1'b1;
              state_next = ST_MUL;
            end
          end
          default: begin
            res_next = direct;
            state_next = ST_EMIT;
          end
        endcase
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_SINE;
        end
      end
      ST_SINE: begin
        res_next = neg ? -rom_ext : rom_ext;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || rsp.ready) begin
          out_load = 1'b1;
          phase_next = phase + phase_inc;
          cnt_next = cnt - CNT_W'(1);
          state_next = (cnt == CNT_W'(1)) ? ST_IDLE : ST_CALC;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      phase <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      phase <= phase_next;
      out_valid <= out_load || (out_valid && !rsp.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform <= WAVE_SINE;
      phase_inc <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVEFORM: waveform <= cfg_data[WAVE_BITS-1:0];
        REG_PHASE_INCREMENT: phase_inc <= cfg_data[PHASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sign of the quadrant travels with the table read
  always_ff @(posedge clk) begin
    res <= res_next;
    neg <= quad[1];
    if (out_load) begin
      out_sample <= res;
      out_last <= (cnt == CNT_W'(1));
    end
  end

endmodule

`default_nettype wire

@@ src/mwpo_checker.sv @@
// port-level checks for the oscillator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module mwpo_checker import mwpo_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   req_valid,
  input wire logic                   req_ready,
  input wire logic [FRAME_BITS-1:0]  req_frame_count,
  input wire logic                   rsp_valid,
  input wire logic                   rsp_ready,
  input wire logic [SAMPLE_BITS-1:0] rsp_sample,
  input wire logic                   rsp_last
);

  // a stalled sample holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_last))
    else $error("sample changed while stalled");

  // reset leaves the block empty and taking requests
  a_reset_idle: assert property (@(posedge clk)
    rst |=> req_ready && !rsp_valid)
    else $error("not idle after reset");

  // a request with samples to give occupies the block
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_frame_count != '0) |=> !req_ready)
    else $error("request accepted but block still ready");

  // a sample that is not the last one means the request is still running
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> !req_ready)
    else $error("ready while a request is unfinished");

endmodule

bind multi_waveform_phase_oscillator mwpo_checker u_mwpo_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_frame_count (req.frame_count),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_sample      (rsp.sample),
  .rsp_last        (rsp.last)
);

`default_nettype wire
